### rtl/cte_pkg.sv
`default_nettype none

package cte_pkg;

  // action codes
  localparam logic [2:0] ACT_LEFT   = 3'd0;
  localparam logic [2:0] ACT_RIGHT  = 3'd1;
  localparam logic [2:0] ACT_BACK   = 3'd2;
  localparam logic [2:0] ACT_INSERT = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_END   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_in;
    logic [9:0] read_pos;
  } cte_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  char_out;
    logic [10:0] cursor_pos;
    logic [10:0] text_length;
  } cte_out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } cte_state_t;

endpackage

`default_nettype wire

### rtl/cte_store.sv
`default_nettype none

module cte_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/cursor_text_buffer_editor.sv
// Line editor with a cursor, held as a gap buffer in one byte store with a read and a write port.
// Characters left of the cursor sit at the bottom of the store, those right of it
// at the top, with the gap in between.
//
// Input channel: in_data (action, char_in, read_pos) is taken at a rising edge where
// start is high and busy is low. Busy is high in the cycle after that, the execute state.
// Result channel: out_valid strobes for exactly one cycle with out_data; the receiver
// cannot hold it off, so nothing is ever stalled on the output side.
//
// Timing: the store is read on the accept edge and written back on the following edge,
// in the execute state. The result is registered at that write-back edge and shows in
// the same cycle the block is ready again; a new word is not taken while the block is
// still busy with the last one.
//
// Reset (rst_n low, synchronous) empties the text and puts the cursor at position 0.
// The store contents are not cleared: only written entries are ever read back.
`default_nettype none

module cursor_text_buffer_editor
  import cte_pkg::*;
#(
  parameter int BUFFER_DEPTH = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire cte_in_t  in_data,
  output logic          out_valid,
  output cte_out_t      out_data
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 10) ? CNT_W : 10;
  localparam int EXT_W  = (CNT_W > 11) ? CNT_W : 11;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

  cte_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] right_r, right_nxt;
  logic [2:0]       act_r;
  logic [7:0]       char_r;
  logic [9:0]       pos_r;
  logic             out_valid_r;
  cte_out_t         out_r, out_nxt;

  logic              accept;
  logic [CNT_W-1:0]  total;
  logic [CMP_W-1:0]  pos_in_c, left_c, right_c, raddr_full;
  logic [CMP_W-1:0]  pos_r_c, total_c;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic              we;
  logic [CNT_W-1:0]  waddr_full;
  logic [7:0]        wdata;
  logic [1:0]        status;
  logic [7:0]        char_rd;
  logic [CNT_W-1:0]  total_nxt;
  logic [EXT_W-1:0]  left_ext, total_ext;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_EXEC);
  assign total  = left_r + right_r;

  assign pos_in_c = CMP_W'(in_data.read_pos);
  assign left_c   = CMP_W'(left_r);
  assign right_c  = CMP_W'(right_r);

  // read address for the word being accepted
  always_comb begin
    raddr_full = '0;
    unique case (in_data.action)
      ACT_LEFT:  raddr_full = CMP_W'(left_r - CNT_W'(1));
      ACT_RIGHT: raddr_full = CMP_W'(DEPTH_C - right_r);
      ACT_READ: begin
        if (pos_in_c < left_c) begin
          raddr_full = pos_in_c;
        end else begin
          raddr_full = CMP_W'(DEPTH_C) - right_c + (pos_in_c - left_c);
        end
      end
      default:   raddr_full = '0;
    endcase
  end

  assign raddr = raddr_full[ADDR_W-1:0];

  cte_store #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr_full[ADDR_W-1:0]),
    .wdata (wdata)
  );

  assign pos_r_c = CMP_W'(pos_r);
  assign total_c = CMP_W'(total);

  // write-back and count update in the execute cycle
  always_comb begin
    left_nxt   = left_r;
    right_nxt  = right_r;
    we         = 1'b0;
    waddr_full = left_r;
    wdata      = rdata;
    status     = STAT_DONE;
    char_rd    = 8'd0;
    if (state_r == ST_EXEC) begin
      unique case (act_r)
        ACT_LEFT: begin
          if (left_r == '0) begin
            status = STAT_END;
          end else begin
            we         = 1'b1;
            waddr_full = DEPTH_C - right_r - CNT_W'(1);
            left_nxt   = left_r - CNT_W'(1);
            right_nxt  = right_r + CNT_W'(1);
          end
        end
        ACT_RIGHT: begin
          if (right_r == '0) begin
            status = STAT_END;
          end else begin
            we        = 1'b1;
            left_nxt  = left_r + CNT_W'(1);
            right_nxt = right_r - CNT_W'(1);
          end
        end
        ACT_BACK: begin
          if (left_r == '0) begin
            status = STAT_END;
          end else begin
            left_nxt = left_r - CNT_W'(1);
          end
        end
        ACT_INSERT: begin
          if (total >= DEPTH_C) begin
            status = STAT_FULL;
          end else begin
            we       = 1'b1;
            wdata    = char_r;
            left_nxt = left_r + CNT_W'(1);
          end
        end
        ACT_READ: begin
          if (pos_r_c >= total_c) begin
            status = STAT_RANGE;
          end else begin
            char_rd = rdata;
          end
        end
        default: status = STAT_DONE;
      endcase
    end
  end

  assign total_nxt = left_nxt + right_nxt;
  assign left_ext  = EXT_W'(left_nxt);
  assign total_ext = EXT_W'(total_nxt);

  always_comb begin
    out_nxt.status      = status;
    out_nxt.char_out    = char_rd;
    out_nxt.cursor_pos  = left_ext[10:0];
    out_nxt.text_length = total_ext[10:0];
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_data.action;
      char_r <= in_data.char_in;
      pos_r  <= in_data.read_pos;
    end
    if (state_r == ST_EXEC) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/cte_checker.sv
`default_nettype none

module cte_checker
  import cte_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire cte_out_t out_data
);

  logic accept;
  assign accept = start && !busy;

  // a taken word raises busy, which blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  // every word gives its result, registered at the end of the execute state
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // the block is ready again once a result shows
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result shown");

  // only a successful read returns a character
  a_char_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STAT_DONE)) |-> (out_data.char_out == 8'd0))
    else $error("character returned with failing status");

endmodule

bind cursor_text_buffer_editor cte_checker u_cte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

### tb/sv/cursor_text_buffer_editor_checker.sv
`timescale 1ns / 1ps

module cursor_text_buffer_editor_checker
  import cte_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire cte_in_t  in_data,
  input  wire logic     out_valid,
  input  wire cte_out_t out_data,
  output int            mismatches,
  output int            pending
);

  // own copy of the gap buffer: left part from the bottom, right part from the top
  logic [7:0] text_mem [DEPTH];
  int         n_left;
  int         n_right;

  cte_out_t   expected_results [$];

  function automatic cte_out_t edit_text(cte_in_t w);
    cte_out_t r;
    int       total;
    total = n_left + n_right;
    r = '0;
    r.status = STAT_DONE;
    case (w.action)
      ACT_LEFT: begin
        if (n_left == 0) begin
          r.status = STAT_END;
        end else begin
          text_mem[DEPTH - n_right - 1] = text_mem[n_left - 1];
          n_left--;
          n_right++;
        end
      end
      ACT_RIGHT: begin
        if (n_right == 0) begin
          r.status = STAT_END;
        end else begin
          text_mem[n_left] = text_mem[DEPTH - n_right];
          n_left++;
          n_right--;
        end
      end
      ACT_BACK: begin
        if (n_left == 0) r.status = STAT_END;
        else n_left--;
      end
      ACT_INSERT: begin
        if (total >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          text_mem[n_left] = w.char_in;
          n_left++;
        end
      end
      ACT_READ: begin
        if (int'(w.read_pos) >= total) r.status = STAT_RANGE;
        else if (int'(w.read_pos) < n_left) r.char_out = text_mem[w.read_pos];
        else r.char_out = text_mem[DEPTH - n_right + (int'(w.read_pos) - n_left)];
      end
      default: ;
    endcase
    r.cursor_pos  = 11'(n_left);
    r.text_length = 11'(n_left + n_right);
    return r;
  endfunction

  always @(posedge clk) begin
    cte_out_t want;
    if (!rst_n) begin
      n_left = 0;
      n_right = 0;
      mismatches = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      // compare first: a result never belongs to a word taken at the same edge
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: %p", out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.char_out !== want.char_out) begin
            $error("char_out expected %0d got %0d", want.char_out, out_data.char_out);
            mismatches++;
          end
          if (out_data.cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos expected %0d got %0d", want.cursor_pos, out_data.cursor_pos);
            mismatches++;
          end
          if (out_data.text_length !== want.text_length) begin
            $error("text_length expected %0d got %0d", want.text_length,
                   out_data.text_length);
            mismatches++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(edit_text(in_data));
      pending <= expected_results.size();
    end
  end

endmodule

### tb/sv/cursor_text_buffer_editor_test.sv
`timescale 1ns / 1ps

module cursor_text_buffer_editor_test;
  import cte_pkg::*;

  localparam int DEPTH = 1024;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cte_in_t  in_data;
  logic     out_valid;
  cte_out_t out_data;
  int       mismatches;
  int       pending;

  cursor_text_buffer_editor #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  cursor_text_buffer_editor_checker #(.DEPTH(DEPTH)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cte_in_t edit_word(logic [2:0] act, logic [7:0] ch, logic [9:0] pos);
    cte_in_t w;
    w.action   = act;
    w.char_in  = ch;
    w.read_pos = pos;
    return w;
  endfunction

  // holds start high until the word is taken
  task automatic send_word(cte_in_t w);
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // weights in percent; what is left over goes to the unused action codes
  task automatic random_words(int count, int p_left, int p_right, int p_back, int p_ins,
                              int p_read, bit idling);
    cte_in_t    w;
    int         roll;
    logic [2:0] act;
    logic [9:0] pos;
    bit         idle_burst;
    idle_burst = 1'b0;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < p_left) act = ACT_LEFT;
      else if (roll < p_left + p_right) act = ACT_RIGHT;
      else if (roll < p_left + p_right + p_back) act = ACT_BACK;
      else if (roll < p_left + p_right + p_back + p_ins) act = ACT_INSERT;
      else if (roll < p_left + p_right + p_back + p_ins + p_read) act = ACT_READ;
      else act = ACT_READ + 3'($urandom_range(1, 3));
      // short texts need small positions to land inside
      pos = $urandom_range(0, 1) ? 10'($urandom_range(0, 63)) : 10'($urandom_range(0, 1023));
      w = edit_word(act, 8'($urandom_range(0, 255)), pos);
      send_word(w);
      // idling switches on and off so there are stretches at full rate too
      if ($urandom_range(0, 49) == 0) idle_burst = ~idle_burst;
      if (idling && idle_burst && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 14));
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ends of an empty text, then inserts, reads, cursor moves and the unused action codes
    send_word(edit_word(ACT_LEFT,   8'h00, 10'd0));
    send_word(edit_word(ACT_RIGHT,  8'h00, 10'd0));
    send_word(edit_word(ACT_BACK,   8'hFF, 10'h3FF));
    send_word(edit_word(ACT_READ,   8'h00, 10'd0));
    send_word(edit_word(ACT_READ,   8'hFF, 10'h3FF));
    send_word(edit_word(ACT_INSERT, 8'h00, 10'h3FF));
    send_word(edit_word(ACT_INSERT, 8'hFF, 10'd0));
    send_word(edit_word(ACT_INSERT, 8'hA5, 10'd0));
    send_word(edit_word(ACT_INSERT, 8'h5A, 10'd0));
    send_word(edit_word(ACT_READ,   8'h00, 10'd0));
    send_word(edit_word(ACT_READ,   8'h00, 10'd3));
    send_word(edit_word(ACT_READ,   8'h00, 10'd4));
    send_word(edit_word(ACT_RIGHT,  8'h00, 10'd0));
    send_word(edit_word(ACT_LEFT,   8'h00, 10'd0));
    send_word(edit_word(ACT_LEFT,   8'h00, 10'd0));
    send_word(edit_word(ACT_READ,   8'h00, 10'd1));
    send_word(edit_word(ACT_READ,   8'h00, 10'd3));
    send_word(edit_word(ACT_BACK,   8'h00, 10'd0));
    send_word(edit_word(ACT_INSERT, 8'h3C, 10'd0));
    send_word(edit_word(ACT_RIGHT,  8'h00, 10'd0));
    send_word(edit_word(ACT_READ,   8'h00, 10'd2));
    send_word(edit_word(ACT_READ + 3'd1, 8'hFF, 10'h3FF));
    send_word(edit_word(ACT_READ + 3'd2, 8'h00, 10'd0));
    send_word(edit_word(ACT_READ + 3'd3, 8'h00, 10'd0));
    wait_all_results();

    random_words(500, 15, 10, 10, 45, 15, 1'b1);
    wait_all_results();

    // fill to the brim and keep pushing against the full buffer
    random_words(1100, 2, 2, 0, 93, 3, 1'b1);
    wait_all_results();

    // cursor wanders through a long text, full rate to the end
    random_words(300, 35, 15, 10, 15, 20, 1'b0);
    wait_all_results();
    repeat (4) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("cursor_text_buffer_editor: match");
    end else begin
      $display("cursor_text_buffer_editor: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("cursor_text_buffer_editor: mismatch");
    $finish;
  end

endmodule
